FILE: sv/cartridge_bank_controller_type2_unit_assert.svh
// Assertion macros used by the bank controller queue.
`ifndef CARTRIDGE_BANK_CONTROLLER_TYPE2_UNIT_ASSERT_SVH
`define CARTRIDGE_BANK_CONTROLLER_TYPE2_UNIT_ASSERT_SVH
`ifndef SYNTH
// Checks that the consequent holds in the same cycle as the antecedent.
`define CBC2_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cbc2 assertion failed");
// Checks that the consequent holds in the cycle after the antecedent.
`define CBC2_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cbc2 assertion failed");
`else
`define CBC2_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define CBC2_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: sv/cbc2_pkg.sv
// Types and constants shared by the bank controller modules.
package cbc2_pkg;

    localparam int ADDR_W       = 16;
    localparam int DATA_W       = 8;
    localparam int ROM_ADDR_W   = 18;
    localparam int BANK_W       = 4;
    localparam int RAM_DEPTH_DEF = 512;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [BANK_W-1:0] BANK_RESET  = 4'h1;
    localparam logic [3:0]        ENABLE_KEY  = 4'hA;
    localparam logic [DATA_W-1:0] BYTE_OPEN   = 8'hFF;
    localparam logic [DATA_W-1:0] BYTE_ZERO   = 8'h00;

    typedef enum logic [1:0] {
        OP_CONST,
        OP_RAM_RD,
        OP_RAM_WR
    } t_op;

    // One classified access, as handed from the front to the back.
    typedef struct packed {
        t_op                    op;
        logic                   rom_access;
        logic [ROM_ADDR_W-1:0]  rom_address;
        logic [DATA_W-1:0]      rd_byte;
        logic [DATA_W-1:0]      wr_byte;
        logic [ADDR_W-1:0]      bus_address;
    } t_entry;

endpackage

FILE: sv/cartridge_bank_controller_type2_unit.sv
// An accepted beat is written into the queue; a pop moves it into the output register.
// Throughput: one beat per cycle while unstalled, set by the back end's single-port RAM.
// The front accepts while the two-entry queue has room, even if the output is stalled.
// Reset (synchronous, active low): bank register 1, RAM disabled, queue and output empty.
// RAM contents are not cleared; an entry reads as anything until first written.
// The RAM depth must be a power of two, since the RAM index is the low address bits.
module cartridge_bank_controller_type2_unit #(
    parameter int RAM_DEPTH   = cbc2_pkg::RAM_DEPTH_DEF,
    parameter int QUEUE_DEPTH = cbc2_pkg::QUEUE_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input channel: one bus access per beat.
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_req_type,
    input  logic [cbc2_pkg::ADDR_W-1:0]       i_bus_address,
    input  logic [cbc2_pkg::DATA_W-1:0]       i_write_byte,
    // Output channel: one result per beat.
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [cbc2_pkg::DATA_W-1:0]       o_read_byte,
    output logic                              o_rom_access,
    output logic [cbc2_pkg::ROM_ADDR_W-1:0]   o_rom_address
);

    logic             push, pop, full, nonempty;
    cbc2_pkg::t_entry front_entry, head_entry;

    // The front applies bank and enable writes in arrival order and resolves
    // every ROM address, so the back only has to touch the RAM.
    cbc2_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_in_valid),
        .i_full        (full),
        .i_req_type    (i_req_type),
        .i_bus_address (i_bus_address),
        .i_write_byte  (i_write_byte),
        .o_push        (push),
        .o_entry       (front_entry)
    );

    // The stall seen by the sender is just the registered queue-full state.
    assign o_in_stall = full;

    cbc2_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_entry    (front_entry),
        .i_pop      (pop),
        .o_full     (full),
        .o_nonempty (nonempty),
        .o_head     (head_entry)
    );

    // The back pops when its output register is free or being drained,
    // performing the RAM read or write in the same cycle as the pop.
    cbc2_back #(
        .RAM_DEPTH (RAM_DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_nonempty    (nonempty),
        .i_head        (head_entry),
        .o_pop         (pop),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_read_byte   (o_read_byte),
        .o_rom_access  (o_rom_access),
        .o_rom_address (o_rom_address)
    );

endmodule

FILE: sv/cbc2_ram.sv
// Generic single-port RAM with registered read data.
module cbc2_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/cbc2_front.sv
// Front end: accepts bus accesses, updates bank and enable registers, classifies.
module cbc2_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic                          i_full,
    input  logic                          i_req_type,
    input  logic [cbc2_pkg::ADDR_W-1:0]   i_bus_address,
    input  logic [cbc2_pkg::DATA_W-1:0]   i_write_byte,
    output logic                          o_push,
    output cbc2_pkg::t_entry              o_entry
);

    logic [cbc2_pkg::BANK_W-1:0] r_bank, n_bank;
    logic                        r_ram_en, n_ram_en;
    logic                        accept;
    logic                        in_low, in_switched, in_ram;
    logic [3:0]                  nibble;

    assign accept      = i_valid && !i_full;
    assign in_low      = (i_bus_address[15:14] == 2'b00);
    assign in_switched = (i_bus_address[15:14] == 2'b01);
    assign in_ram      = (i_bus_address[15:13] == 3'b101);
    assign nibble      = i_write_byte[3:0];

    always_comb begin
        n_bank   = r_bank;
        n_ram_en = r_ram_en;

        o_entry             = '0;
        o_entry.op          = cbc2_pkg::OP_CONST;
        o_entry.wr_byte     = i_write_byte;
        o_entry.bus_address = i_bus_address;

        if (i_req_type) begin
            if (in_low) begin
                // Address bit 8 picks the bank register over the enable flag.
                if (i_bus_address[8]) begin
                    n_bank = (nibble == 4'h0) ? cbc2_pkg::BANK_RESET : nibble;
                end else begin
                    n_ram_en = (nibble == cbc2_pkg::ENABLE_KEY);
                end
            end else if (in_ram && r_ram_en) begin
                o_entry.op = cbc2_pkg::OP_RAM_WR;
            end
        end else begin
            if (in_low) begin
                o_entry.rom_access  = 1'b1;
                o_entry.rom_address = {2'b00, i_bus_address};
            end else if (in_switched) begin
                o_entry.rom_access  = 1'b1;
                o_entry.rom_address = {r_bank, i_bus_address[13:0]};
            end else if (in_ram) begin
                if (r_ram_en) begin
                    o_entry.op = cbc2_pkg::OP_RAM_RD;
                end else begin
                    o_entry.rd_byte = cbc2_pkg::BYTE_OPEN;
                end
            end
        end
    end

    assign o_push = accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank   <= cbc2_pkg::BANK_RESET;
            r_ram_en <= 1'b0;
        end else if (accept) begin
            r_bank   <= n_bank;
            r_ram_en <= n_ram_en;
        end
    end

endmodule

FILE: sv/cbc2_queue.sv
// Short FIFO of classified accesses between the front and the back.
`include "cartridge_bank_controller_type2_unit_assert.svh"
module cbc2_queue #(
    parameter int DEPTH = cbc2_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  cbc2_pkg::t_entry i_entry,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_nonempty,
    output cbc2_pkg::t_entry o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cbc2_pkg::t_entry   r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count, n_count;

    assign o_full     = (r_count == CNT_W'(DEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_head     = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    `CBC2_ASSERT_IMPLY(a_no_push_when_full, i_clk, i_rst_n, i_push, !o_full)
    `CBC2_ASSERT_IMPLY(a_no_pop_when_empty, i_clk, i_rst_n, i_pop, o_nonempty)
    `CBC2_ASSERT_NEXT(a_count_tracks, i_clk, i_rst_n, i_push != i_pop, r_count != $past(r_count))

endmodule

FILE: sv/cbc2_back.sv
// Back end: carries out RAM accesses in order and holds the result beat.
module cbc2_back #(
    parameter int RAM_DEPTH = cbc2_pkg::RAM_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_nonempty,
    input  cbc2_pkg::t_entry                  i_head,
    output logic                              o_pop,
    input  logic                              i_out_stall,
    output logic                              o_out_valid,
    output logic [cbc2_pkg::DATA_W-1:0]       o_read_byte,
    output logic                              o_rom_access,
    output logic [cbc2_pkg::ROM_ADDR_W-1:0]   o_rom_address
);

    localparam int IDX_W = $clog2(RAM_DEPTH);

    logic                               r_valid;
    logic                               r_from_ram;
    logic [cbc2_pkg::DATA_W-1:0]        r_byte;
    logic                               r_rom_access;
    logic [cbc2_pkg::ROM_ADDR_W-1:0]    r_rom_address;
    logic [cbc2_pkg::DATA_W-1:0]        ram_rdata;
    logic                               ram_we, ram_re;

    // The RAM read data register only moves on a pop, so it holds while stalled.
    assign o_pop  = i_nonempty && (!r_valid || !i_out_stall);
    assign ram_we = o_pop && (i_head.op == cbc2_pkg::OP_RAM_WR);
    assign ram_re = o_pop && (i_head.op == cbc2_pkg::OP_RAM_RD);

    cbc2_ram #(
        .WIDTH (cbc2_pkg::DATA_W),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (i_head.bus_address[IDX_W-1:0]),
        .i_wdata (i_head.wr_byte),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_from_ram    <= (i_head.op == cbc2_pkg::OP_RAM_RD);
            r_byte        <= i_head.rd_byte;
            r_rom_access  <= i_head.rom_access;
            r_rom_address <= i_head.rom_address;
        end
    end

    assign o_out_valid   = r_valid;
    assign o_read_byte   = r_from_ram ? ram_rdata : r_byte;
    assign o_rom_access  = r_rom_access;
    assign o_rom_address = r_rom_address;

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for the type 2 cartridge bank controller unit.
`timescale 1ns / 100ps

module testbench;

    // Field widths taken over from the shared package.
    localparam int ADDR_W     = cbc2_pkg::ADDR_W;
    localparam int DATA_W     = cbc2_pkg::DATA_W;
    localparam int ROM_ADDR_W = cbc2_pkg::ROM_ADDR_W;
    localparam int BANK_W     = cbc2_pkg::BANK_W;

    // Access kinds on the request channel.
    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    // Bus address map of the controller.
    localparam logic [ADDR_W-1:0] ROM_SWITCH_BASE = 16'h4000;
    localparam logic [ADDR_W-1:0] ROM_END         = 16'h8000;
    localparam logic [ADDR_W-1:0] RAM_BASE        = 16'hA000;
    localparam logic [ADDR_W-1:0] RAM_END         = 16'hC000;
    localparam int                BANK_SEL_BIT    = 8;
    localparam int                RAM_WORDS       = cbc2_pkg::RAM_DEPTH_DEF;
    localparam int                ROM_BANK_BYTES  = 16'h4000;

    // Run shape.
    localparam int NUM_RANDOM    = 1300;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int PRINT_CAP     = 40;

    // Idling phases, stepped through as the run progresses.
    localparam int PHASE_FREE    = 0;
    localparam int PHASE_SENDER  = 1;
    localparam int PHASE_STALL   = 2;
    localparam int PHASE_BOTH    = 3;

    typedef struct packed {
        logic              req_type;
        logic [ADDR_W-1:0] bus_address;
        logic [DATA_W-1:0] write_byte;
    } t_bus_access;

    typedef struct packed {
        logic [DATA_W-1:0]     read_byte;
        logic                  rom_access;
        logic [ROM_ADDR_W-1:0] rom_address;
    } t_bus_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic                  i_req_type = REQ_READ;
    logic [ADDR_W-1:0]     i_bus_address = '0;
    logic [DATA_W-1:0]     i_write_byte = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [DATA_W-1:0]     o_read_byte;
    logic                  o_rom_access;
    logic [ROM_ADDR_W-1:0] o_rom_address;

    cartridge_bank_controller_type2_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_req_type    (i_req_type),
        .i_bus_address (i_bus_address),
        .i_write_byte  (i_write_byte),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_read_byte   (o_read_byte),
        .o_rom_access  (o_rom_access),
        .o_rom_address (o_rom_address)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Accesses waiting to be driven, and results waiting to come out, in order.
    t_bus_access pending_accesses[$];
    t_bus_result expected_results[$];

    // Mirror of the controller state, advanced as each beat is accepted.
    logic [BANK_W-1:0] bank_reg = cbc2_pkg::BANK_RESET;
    logic              ram_on = 1'b0;
    logic [DATA_W-1:0] ram_copy [RAM_WORDS];

    // Stimulus-side view of the same state, advanced as accesses are queued.
    // Because beats are accepted in queue order, it tells the generator which
    // RAM entries hold data at the moment a later read will reach the block.
    logic              plan_ram_on = 1'b0;
    bit                plan_written [RAM_WORDS];
    int                written_slots[$];

    int unsigned total_accesses = 1;
    int unsigned beats_in = 0;
    int unsigned beats_out = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    int unsigned rom_fetches = 0;
    int unsigned ram_reads = 0;
    int unsigned ram_stores = 0;
    int unsigned bank_selects = 0;

    task automatic report_mismatch(input string what);
        if (mismatch_count < PRINT_CAP)
            $display("MISMATCH at cycle %0d: %s", cycle_count, what);
        mismatch_count++;
    endtask

    function automatic bit in_ram_window(input logic [ADDR_W-1:0] addr);
        return addr >= RAM_BASE && addr < RAM_END;
    endfunction

    // Works out the result of one accepted access and applies its side effects
    // to the mirrored bank register, enable flag and RAM.
    function automatic t_bus_result decode_access(input t_bus_access acc);
        t_bus_result res;
        logic [3:0]  nibble;
        int          slot;
        res    = '0;
        nibble = acc.write_byte[3:0];
        slot   = acc.bus_address % RAM_WORDS;
        if (acc.req_type == REQ_WRITE) begin
            if (acc.bus_address < ROM_SWITCH_BASE) begin
                // Address bit 8 picks the bank register over the enable flag.
                if (!acc.bus_address[BANK_SEL_BIT]) begin
                    ram_on = (nibble == cbc2_pkg::ENABLE_KEY);
                end else begin
                    bank_reg = (nibble == 4'h0) ? cbc2_pkg::BANK_RESET : nibble;
                    bank_selects++;
                end
            end else if (in_ram_window(acc.bus_address) && ram_on) begin
                ram_copy[slot] = acc.write_byte;
                ram_stores++;
            end
        end else begin
            if (acc.bus_address < ROM_SWITCH_BASE) begin
                res.rom_access  = 1'b1;
                res.rom_address = ROM_ADDR_W'(acc.bus_address);
                rom_fetches++;
            end else if (acc.bus_address < ROM_END) begin
                res.rom_access  = 1'b1;
                res.rom_address = ROM_ADDR_W'(bank_reg) * ROM_ADDR_W'(ROM_BANK_BYTES)
                                + ROM_ADDR_W'(acc.bus_address[13:0]);
                rom_fetches++;
            end else if (in_ram_window(acc.bus_address)) begin
                res.read_byte = ram_on ? ram_copy[slot] : cbc2_pkg::BYTE_OPEN;
                ram_reads++;
            end else begin
                res.read_byte = cbc2_pkg::BYTE_ZERO;
            end
        end
        return res;
    endfunction

    // Queues one access. A read of an enabled RAM entry that holds no data yet
    // would return garbage, so such a read is turned into a store to the entry.
    task automatic add_access(input logic req_type, input logic [ADDR_W-1:0] addr,
                              input logic [DATA_W-1:0] data);
        t_bus_access acc;
        int          slot;
        slot = addr % RAM_WORDS;
        acc  = '{req_type: req_type, bus_address: addr, write_byte: data};
        if (req_type == REQ_READ && in_ram_window(addr) && plan_ram_on && !plan_written[slot])
            acc.req_type = REQ_WRITE;
        if (acc.req_type == REQ_WRITE) begin
            if (addr < ROM_SWITCH_BASE && !addr[BANK_SEL_BIT]) begin
                plan_ram_on = (data[3:0] == cbc2_pkg::ENABLE_KEY);
            end else if (in_ram_window(addr) && plan_ram_on && !plan_written[slot]) begin
                plan_written[slot] = 1'b1;
                written_slots.push_back(slot);
            end
        end
        pending_accesses.push_back(acc);
    endtask

    // The idling phase follows how far the request stream has got, so each
    // quarter of the run sees a different mix of sender gaps and output stalls.
    function automatic int idle_phase();
        int unsigned q;
        q = (beats_in * 4) / total_accesses;
        return (q > PHASE_BOTH) ? PHASE_BOTH : int'(q);
    endfunction

    function automatic bit sender_idles();
        case (idle_phase())
            PHASE_SENDER: return $urandom_range(99) < 85;
            PHASE_BOTH:   return $urandom_range(99) < 29;
            default:      return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stalls();
        case (idle_phase())
            PHASE_STALL: return $urandom_range(99) < 85;
            PHASE_BOTH:  return $urandom_range(99) < 29;
            default:     return 1'b0;
        endcase
    endfunction

    // Request driver. A beat that has been offered stays on the ports until
    // the block takes it; the expected result is computed at that edge.
    always @(posedge i_clk) begin : request_driver
        t_bus_access nxt;
        bit          taken;
        if (i_rst_n) begin
            taken = i_in_valid && !o_in_stall;
            if (taken) begin
                expected_results.push_back(decode_access('{req_type: i_req_type,
                                                           bus_address: i_bus_address,
                                                           write_byte: i_write_byte}));
                beats_in++;
            end
            if (!i_in_valid || taken) begin
                if (pending_accesses.size() > 0 && !sender_idles()) begin
                    nxt = pending_accesses.pop_front();
                    i_in_valid    <= 1'b1;
                    i_req_type    <= nxt.req_type;
                    i_bus_address <= nxt.bus_address;
                    i_write_byte  <= nxt.write_byte;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor. Each beat leaving the block is checked against the oldest
    // expectation, field by field; the stall for the next edge is drawn here.
    always @(posedge i_clk) begin : result_monitor
        t_bus_result want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result beat with no access outstanding");
                end else begin
                    want = expected_results.pop_front();
                    if (o_read_byte !== want.read_byte)
                        report_mismatch($sformatf("beat %0d read_byte %02h, expected %02h",
                                                  beats_out, o_read_byte, want.read_byte));
                    if (o_rom_access !== want.rom_access)
                        report_mismatch($sformatf("beat %0d rom_access %0b, expected %0b",
                                                  beats_out, o_rom_access, want.rom_access));
                    if (o_rom_address !== want.rom_address)
                        report_mismatch($sformatf("beat %0d rom_address %05h, expected %05h",
                                                  beats_out, o_rom_address, want.rom_address));
                end
                beats_out++;
            end
            i_out_stall <= receiver_stalls();
        end
    end

    // A hung handshake ends the run here.
    always @(posedge i_clk) begin : watchdog
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Run stopped after %0d cycles with %0d results outstanding.",
                     cycle_count, expected_results.size());
            $display("FAIL cartridge_bank_controller_type2_unit");
            $finish;
        end
    end

    initial begin : stimulus
        int                kind;
        int                slot;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        logic              rtype;

        // Directed opening: window edges, reset bank, disabled RAM, enable and
        // bank register writes, RAM echo across the window and the zero-bank rule.
        add_access(REQ_READ,  16'h0000, 8'h00);   // fixed ROM, lowest address
        add_access(REQ_READ,  16'h3FFF, 8'hFF);   // fixed ROM, top
        add_access(REQ_READ,  16'h4000, 8'h00);   // switched ROM on the reset bank
        add_access(REQ_READ,  16'h7FFF, 8'h00);
        add_access(REQ_READ,  16'hA000, 8'h00);   // RAM disabled reads open bus
        add_access(REQ_READ,  16'hBFFF, 8'h00);
        add_access(REQ_READ,  16'h8000, 8'h00);   // unmapped areas read zero
        add_access(REQ_READ,  16'hFFFF, 8'h00);
        add_access(REQ_READ,  16'hC000, 8'h00);
        add_access(REQ_WRITE, 16'hA000, 8'h55);   // store while disabled is dropped
        add_access(REQ_WRITE, 16'h0000, 8'h0A);   // enable RAM
        add_access(REQ_WRITE, 16'hA000, 8'h00);
        add_access(REQ_WRITE, 16'hBFFF, 8'hFF);   // last RAM entry
        add_access(REQ_READ,  16'hA000, 8'h00);
        add_access(REQ_READ,  16'hA1FF, 8'h00);   // echo of the last entry
        add_access(REQ_WRITE, 16'h0100, 8'h00);   // zero nibble selects bank 1
        add_access(REQ_READ,  16'h7FFF, 8'h00);
        add_access(REQ_WRITE, 16'h01FF, 8'h10);   // only four bank bits: bank 1 again
        add_access(REQ_WRITE, 16'h3FFF, 8'hFF);   // highest bank
        add_access(REQ_READ,  16'h4000, 8'h00);
        add_access(REQ_WRITE, 16'h3EFF, 8'h1A);   // enable key with high bits set
        add_access(REQ_WRITE, 16'h00FF, 8'h0B);   // any other nibble disables
        add_access(REQ_READ,  16'hB000, 8'h00);
        add_access(REQ_WRITE, 16'h0000, 8'hFA);
        add_access(REQ_WRITE, 16'h8000, 8'h77);   // writes outside the map do nothing
        add_access(REQ_WRITE, 16'hC000, 8'h12);
        add_access(REQ_READ,  16'hB000, 8'h00);

        // Random part: mostly a working cartridge session (RAM enabled, stores
        // followed by reads of stored entries, bank switches and ROM fetches),
        // with a slice of fully random accesses as noise.
        for (int n = 0; n < NUM_RANDOM; n++) begin
            kind  = $urandom_range(99);
            data  = DATA_W'($urandom_range(255));
            addr  = ADDR_W'($urandom_range(16'hFFFF));
            rtype = REQ_READ;
            if (kind < 8) begin
                rtype = REQ_WRITE;
                addr  = ADDR_W'($urandom_range(16'h3FFF));
                addr[BANK_SEL_BIT] = 1'b0;
                if ($urandom_range(9) < 7)
                    data[3:0] = cbc2_pkg::ENABLE_KEY;
            end else if (kind < 18) begin
                rtype = REQ_WRITE;
                addr  = ADDR_W'($urandom_range(16'h3FFF));
                addr[BANK_SEL_BIT] = 1'b1;
                if ($urandom_range(9) == 0)
                    data[3:0] = 4'h0;
            end else if (kind < 43) begin
                rtype = REQ_WRITE;
                addr  = RAM_BASE + ADDR_W'($urandom_range(16'h1FFF));
            end else if (kind < 68) begin
                addr = RAM_BASE + ADDR_W'($urandom_range(16'h1FFF));
                if (written_slots.size() > 0 && $urandom_range(9) != 0) begin
                    slot = written_slots[$urandom_range(written_slots.size() - 1)];
                    addr = RAM_BASE + ADDR_W'($urandom_range(15) * RAM_WORDS + slot);
                end
            end else if (kind < 88) begin
                addr = ADDR_W'($urandom_range(16'h7FFF));
            end else begin
                rtype = 1'($urandom_range(1));
            end
            add_access(rtype, addr, data);
        end
        total_accesses = pending_accesses.size();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_accesses.size() > 0 || i_in_valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        foreach (expected_results[k])
            report_mismatch($sformatf("expected result %0d never came out", k));

        $display("Checked %0d accesses: %0d ROM fetches, %0d RAM reads,",
                 beats_out, rom_fetches, ram_reads);
        $display("%0d RAM stores, %0d bank writes, idling from none to both; %0d mismatches.",
                 ram_stores, bank_selects, mismatch_count);
        if (mismatch_count == 0) begin
            $display("PASS cartridge_bank_controller_type2_unit");
        end else begin
            $display("FAIL cartridge_bank_controller_type2_unit");
        end
        $finish;
    end

endmodule
